FILE: hw/rtl/fat12ct_pkg.sv
package fat12ct_pkg;

  // Default geometry of the table
  localparam int SECTOR_BYTES_DEF  = 512;
  localparam int TABLE_SECTORS_DEF = 9;

  // Entries are 12 bits, so the free search never passes this many clusters
  localparam int CLUSTER_LIMIT = 4096;
  // Bytes covered by all CLUSTER_LIMIT entries
  localparam int SCAN_SPAN     = (CLUSTER_LIMIT / 2) * 3;

  localparam logic [11:0] END_OF_CHAIN = 12'hFFF;

  // Request codes on in_req_type
  localparam logic [2:0] REQ_LOAD   = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_GET    = 3'd2;
  localparam logic [2:0] REQ_SET    = 3'd3;
  localparam logic [2:0] REQ_FIND   = 3'd4;
  localparam logic [2:0] REQ_APPEND = 3'd5;

  // Decoded operation carried through the request queue
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_READ,
    OP_GET,
    OP_SET,
    OP_FIND,
    OP_APPEND
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [12:0] byte_addr;
    logic [7:0]  byte_data;
    logic [11:0] cluster;
    logic [11:0] link_value;
  } req_item_t;

  // Byte offset of a cluster's entry: 3*(c/2) for even, one more for odd
  function automatic logic [12:0] entry_pos(input logic [11:0] c);
    logic [12:0] half;
    half = {2'b00, c[11:1]};
    return (half << 1) + half + {12'd0, c[0]};
  endfunction

endpackage

FILE: hw/rtl/fat12ct_front.sv
module fat12ct_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_req_type,
  input  logic [12:0]            in_byte_addr,
  input  logic [7:0]             in_byte_data,
  input  logic [11:0]            in_cluster,
  input  logic [11:0]            in_link_value,
  output logic                   q_valid,
  output fat12ct_pkg::req_item_t q_item,
  input  logic                   q_pop
);
  import fat12ct_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  req_item_t         slot_r [QDEPTH];
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  req_item_t         item;
  logic              push;

  // Classify the request code
  always_comb begin
    item.byte_addr  = in_byte_addr;
    item.byte_data  = in_byte_data;
    item.cluster    = in_cluster;
    item.link_value = in_link_value;
    unique case (in_req_type)
      REQ_LOAD:   item.op = OP_LOAD;
      REQ_READ:   item.op = OP_READ;
      REQ_GET:    item.op = OP_GET;
      REQ_SET:    item.op = OP_SET;
      REQ_FIND:   item.op = OP_FIND;
      REQ_APPEND: item.op = OP_APPEND;
      default:    item.op = OP_NOP;
    endcase
  end

  assign busy    = (cnt_r == CW'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rptr_r];

  // Advance pointers and fill count
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= item;
    end
  end

endmodule

FILE: hw/rtl/fat12ct_back.sv
module fat12ct_back #(
  parameter int SECTOR_BYTES  = fat12ct_pkg::SECTOR_BYTES_DEF,
  parameter int TABLE_SECTORS = fat12ct_pkg::TABLE_SECTORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  fat12ct_pkg::req_item_t q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [7:0]             out_byte_out,
  output logic [11:0]            out_entry_out,
  output logic                   out_found
);
  import fat12ct_pkg::*;

  localparam int TABLE_LEN = SECTOR_BYTES * TABLE_SECTORS;
  localparam int MAW       = $clog2(TABLE_LEN);
  localparam int XW        = (MAW > 13) ? MAW : 13;
  localparam int SCAN_END  = (TABLE_LEN < SCAN_SPAN) ? TABLE_LEN : SCAN_SPAN;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDB,
    S_LR0,
    S_LR1,
    S_LW0,
    S_LW1,
    S_SCAN
  } state_t;

  logic [7:0] mem [TABLE_LEN];
  logic [7:0] rdata_r;

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [11:0] cl_r, cl_nxt;
  logic [11:0] lw_c_r, lw_c_nxt;
  logic [11:0] lw_v_r, lw_v_nxt;
  logic        second_r, second_nxt;
  logic [11:0] f_r, f_nxt;
  logic [7:0]  b0_r, b0_nxt;
  logic [7:0]  b1_r, b1_nxt;
  logic [12:0] sa_r, sa_nxt;
  logic [1:0]  iph_r, iph_nxt;
  logic [1:0]  rph_r, rph_nxt;
  logic        pend_r, pend_nxt;
  logic [10:0] kc_r, kc_nxt;
  logic [7:0]  h0_r, h0_nxt;
  logic [7:0]  h1_r, h1_nxt;
  logic        rok_r;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic [11:0] oe_r, oe_nxt;
  logic        of_r, of_nxt;

  logic        rd_en, rd_ok, wr_en, wr_ok;
  logic [12:0] rd_addr, wr_addr;
  logic [7:0]  wr_data;
  logic [XW-1:0] rd_x, wr_x;
  logic [12:0] pos, pos1;
  logic [7:0]  rbyte;
  logic        issue, hit;
  logic [11:0] hit_c;

  assign pos   = entry_pos(lw_c_r);
  assign pos1  = pos + 13'd1;
  assign rbyte = rok_r ? rdata_r : 8'h00;
  assign rd_ok = rd_en && (32'(rd_addr) < TABLE_LEN);
  assign wr_ok = wr_en && (32'(wr_addr) < TABLE_LEN);
  assign rd_x  = XW'(rd_addr);
  assign wr_x  = XW'(wr_addr);

  // Scan compare: even entry completes on phase 1, odd entry on phase 2
  assign issue = (32'(sa_r) < SCAN_END);
  always_comb begin
    hit   = 1'b0;
    hit_c = {kc_r, 1'b0};
    if (pend_r && rph_r == 2'd1) begin
      hit = (h0_r == 8'h00) && (rbyte[3:0] == 4'h0);
    end else if (pend_r && rph_r == 2'd2) begin
      hit   = (h1_r[7:4] == 4'h0) && (rbyte == 8'h00);
      hit_c = {kc_r, 1'b1};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cl_nxt     = cl_r;
    lw_c_nxt   = lw_c_r;
    lw_v_nxt   = lw_v_r;
    second_nxt = second_r;
    f_nxt      = f_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;
    sa_nxt     = sa_r;
    iph_nxt    = iph_r;
    rph_nxt    = rph_r;
    pend_nxt   = pend_r;
    kc_nxt     = kc_r;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    ov_nxt     = 1'b0;
    ob_nxt     = 8'h00;
    oe_nxt     = 12'h000;
    of_nxt     = 1'b0;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = q_item.byte_addr;
    wr_en      = 1'b0;
    wr_addr    = q_item.byte_addr;
    wr_data    = q_item.byte_data;

    unique case (state_r)
      // Take the next request and dispatch it
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          op_nxt = q_item.op;
          unique case (q_item.op)
            OP_LOAD: begin
              wr_en  = 1'b1;
              ov_nxt = 1'b1;
            end
            OP_READ: begin
              rd_en     = 1'b1;
              state_nxt = S_RDB;
            end
            OP_GET, OP_SET: begin
              lw_c_nxt  = q_item.cluster;
              lw_v_nxt  = q_item.link_value;
              state_nxt = S_LR0;
            end
            OP_FIND, OP_APPEND: begin
              cl_nxt    = q_item.cluster;
              sa_nxt    = '0;
              iph_nxt   = 2'd0;
              pend_nxt  = 1'b0;
              kc_nxt    = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      // Deliver a raw byte
      S_RDB: begin
        ov_nxt    = 1'b1;
        ob_nxt    = rbyte;
        state_nxt = S_IDLE;
      end

      // Fetch both bytes of the entry
      S_LR0: begin
        rd_en     = 1'b1;
        rd_addr   = pos;
        state_nxt = S_LR1;
      end

      S_LR1: begin
        rd_en     = 1'b1;
        rd_addr   = pos1;
        b0_nxt    = rbyte;
        state_nxt = S_LW0;
      end

      // Compose a link, or write back the first byte
      S_LW0: begin
        if (op_r == OP_GET) begin
          ov_nxt    = 1'b1;
          oe_nxt    = lw_c_r[0] ? {rbyte, b0_r[7:4]} : {rbyte[3:0], b0_r};
          state_nxt = S_IDLE;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos;
          wr_data   = lw_c_r[0] ? {lw_v_r[3:0], b0_r[3:0]} : lw_v_r[7:0];
          b1_nxt    = rbyte;
          state_nxt = S_LW1;
        end
      end

      // Write back the second byte, then chain the end mark on append
      S_LW1: begin
        wr_en   = 1'b1;
        wr_addr = pos1;
        wr_data = lw_c_r[0] ? lw_v_r[11:4] : {b1_r[7:4], lw_v_r[11:8]};
        if (op_r == OP_APPEND && !second_r) begin
          second_nxt = 1'b1;
          lw_c_nxt   = f_r;
          lw_v_nxt   = END_OF_CHAIN;
          state_nxt  = S_LR0;
        end else begin
          ov_nxt    = 1'b1;
          oe_nxt    = (op_r == OP_APPEND) ? f_r : 12'h000;
          of_nxt    = (op_r == OP_APPEND);
          state_nxt = S_IDLE;
        end
      end

      // Stream bytes upward, checking each entry as its last byte returns
      S_SCAN: begin
        rd_en    = issue;
        rd_addr  = sa_r;
        pend_nxt = issue;
        rph_nxt  = iph_r;
        if (issue) begin
          sa_nxt  = sa_r + 13'd1;
          iph_nxt = (iph_r == 2'd2) ? 2'd0 : iph_r + 2'd1;
        end
        if (pend_r) begin
          unique case (rph_r)
            2'd0:    h0_nxt = rbyte;
            2'd1:    h1_nxt = rbyte;
            default: kc_nxt = kc_r + 11'd1;
          endcase
        end
        if (hit) begin
          if (op_r == OP_FIND) begin
            ov_nxt    = 1'b1;
            oe_nxt    = hit_c;
            of_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            f_nxt      = hit_c;
            lw_c_nxt   = cl_r;
            lw_v_nxt   = hit_c;
            second_nxt = 1'b0;
            state_nxt  = S_LR0;
          end
        end else if (!pend_r && !issue) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
      pend_r   <= 1'b0;
      rok_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      pend_r   <= pend_nxt;
      rok_r    <= rd_ok;
      ov_r     <= ov_nxt;
    end
    op_r   <= op_nxt;
    cl_r   <= cl_nxt;
    lw_c_r <= lw_c_nxt;
    lw_v_r <= lw_v_nxt;
    f_r    <= f_nxt;
    b0_r   <= b0_nxt;
    b1_r   <= b1_nxt;
    sa_r   <= sa_nxt;
    iph_r  <= iph_nxt;
    rph_r  <= rph_nxt;
    kc_r   <= kc_nxt;
    h0_r   <= h0_nxt;
    h1_r   <= h1_nxt;
    ob_r   <= ob_nxt;
    oe_r   <= oe_nxt;
    of_r   <= of_nxt;
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_x[MAW-1:0]] <= wr_data;
    end
    if (rd_ok) begin
      rdata_r <= mem[rd_x[MAW-1:0]];
    end
  end

  assign out_valid     = ov_r;
  assign out_byte_out  = ob_r;
  assign out_entry_out = oe_r;
  assign out_found     = of_r;

endmodule

FILE: hw/rtl/fat12_cluster_table_engine_core.sv
// FAT12 allocation table engine.
// Holds the packed table (two 12-bit entries per three bytes) in an on-chip
// byte memory. The host must load every byte with load-byte requests first.
// Input: a request is taken at a rising edge with start high and busy low.
// A two-entry queue sits between the decoder and the executor, so busy only
// rises when two requests are waiting behind the one being carried out.
// Output: every request gives one result, shown for one cycle with out_valid
// high. The receiver cannot hold results off; none are ever dropped.
// Work per request in the executor: load byte writes one byte; read byte
// reads one and returns it; get link reads the entry's two bytes; set link
// reads them and writes both back; unused codes give an all-zero result;
// find free reads bytes upward, one per cycle, up to the first free entry;
// append does the same, links the given cluster to the free one and marks
// the free one as end of chain. With no free entry both scan to the end of
// the table or of entry 4095. A queued request waits for those ahead of it.
// Reset empties the queue and drops work in progress; the table contents
// are kept and stay undefined until loaded.
module fat12_cluster_table_engine_core #(
  parameter int SECTOR_BYTES  = fat12ct_pkg::SECTOR_BYTES_DEF,
  parameter int TABLE_SECTORS = fat12ct_pkg::TABLE_SECTORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [12:0] in_byte_addr,
  input  logic [7:0]  in_byte_data,
  input  logic [11:0] in_cluster,
  input  logic [11:0] in_link_value,
  output logic        out_valid,
  output logic [7:0]  out_byte_out,
  output logic [11:0] out_entry_out,
  output logic        out_found
);
  import fat12ct_pkg::*;

  logic      q_valid;
  logic      q_pop;
  req_item_t q_item;

  fat12ct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_byte_addr  (in_byte_addr),
    .in_byte_data  (in_byte_data),
    .in_cluster    (in_cluster),
    .in_link_value (in_link_value),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  fat12ct_back #(
    .SECTOR_BYTES  (SECTOR_BYTES),
    .TABLE_SECTORS (TABLE_SECTORS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_byte_out  (out_byte_out),
    .out_entry_out (out_entry_out),
    .out_found     (out_found)
  );

  // A full queue always offers a request to the executor
  a_busy_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_valid)
    else $error("queue full but no request offered");

  // Executor never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A found result never carries a raw byte
  a_found_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_byte_out == 8'h00))
    else $error("found result with nonzero byte");

  // Reset leaves no result pending and the queue open
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("output or busy active after reset");

endmodule
